// ===== src/iambic_keyer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Iambic keyer assertion macros
// Shared property forms for the keyer's concurrent checks, clocked on clk
// and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef IAMBIC_KEYER_UNIT_ASSERT_SVH
`define IAMBIC_KEYER_UNIT_ASSERT_SVH

// same-cycle implication
`define IK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ik_pkg.sv =====
// ----------------------------------------------------------------------------
// ik_pkg
// Widths, register indices, operation codes and the result record of the
// iambic keyer.
// ----------------------------------------------------------------------------
package ik_pkg;

  localparam int DIT_W       = 11;  // unit length register
  localparam int LEN_W       = 13;  // element length incl. off unit
  localparam int PAUSE_OUT_W = 20;  // reported pause width
  localparam int CFG_IDX_W   = 2;
  localparam int UNIT_MAX    = (1 << DIT_W) - 1;

  localparam logic [DIT_W-1:0] DIT_TICKS_RESET = DIT_W'(60);

  // register indices
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_B    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSED  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIT_TICKS = 2'd3;

  // item operations
  localparam logic OP_PADDLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef struct packed {
    logic                   element_started;
    logic                   element_is_dit;
    logic [LEN_W-1:0]       element_length;
    logic                   pause_valid;
    logic [PAUSE_OUT_W-1:0] pause_ticks;
    logic                   character_end;
    logic                   keying;
  } ik_result_t;

endpackage

// ===== src/iambic_keyer_unit.sv =====
// ----------------------------------------------------------------------------
// iambic_keyer_unit
// Iambic Morse keyer, modes A and B, driven by paddle updates and 1 ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): each transfer is one item, either a
//    paddle update (op = 0, both physical paddle levels) or a 1 ms tick
//    (op = 1).
//  - Output channel (out_valid/out_stall): exactly one result per item, in
//    order: element start with kind and length, the pause before it, the
//    character end flag and the keying level.
//  - Result: registered, and presented in the cycle after the input transfer.
//  - Throughput: one item per cycle while the output is not stalled; the whole
//    state update is one pass of logic into the result register.
//  - Stall: while a result is held, in_stall follows out_stall, so the next
//    item is taken in the same cycle the held result is transferred.
//  - Configuration (cfg_we/cfg_index/cfg_data) is to be written only while idle (not enforced).
//  - Reset: keyer idle, paddles released, no pause history, enabled, mode A,
//    not reversed, unit of 60 ticks; no result pending.
// ----------------------------------------------------------------------------
module iambic_keyer_unit
  import ik_pkg::*;
#(
  parameter int MAX_UNIT_TICKS = 1200,
  parameter int PAUSE_BITS     = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIT_W-1:0]       cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   op,
  input  logic                   dit_pressed,
  input  logic                   dah_pressed,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   element_started,
  output logic                   element_is_dit,
  output logic [LEN_W-1:0]       element_length,
  output logic                   pause_valid,
  output logic [PAUSE_OUT_W-1:0] pause_ticks,
  output logic                   character_end,
  output logic                   keying
);

  `include "iambic_keyer_unit_assert.svh"

  // unit cap: never above what the unit register can hold
  localparam int UnitCapInt = (MAX_UNIT_TICKS < UNIT_MAX) ? MAX_UNIT_TICKS : UNIT_MAX;
  localparam logic [DIT_W-1:0] UNIT_CAP = DIT_W'(UnitCapInt);
  // pause counter widened (or kept) so the reported field can be cut from it
  localparam int PauseWideW = (PAUSE_BITS > PAUSE_OUT_W) ? PAUSE_BITS : PAUSE_OUT_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIT  = 2'd1,
    ST_DAH  = 2'd2
  } keyer_state_t;

  // configuration registers
  logic             enabled;
  logic             mode_b;
  logic             reversed;
  logic [DIT_W-1:0] dit_ticks;

  // keyer state
  keyer_state_t          keyer_state, keyer_state_next;
  logic                  squeeze_seen, squeeze_seen_next;
  logic                  phys_dit, phys_dit_next;
  logic                  phys_dah, phys_dah_next;
  logic [LEN_W-1:0]      ticks_left, ticks_left_next;
  logic                  idle_seen, idle_seen_next;
  logic [PAUSE_BITS-1:0] idle_ticks, idle_ticks_next;

  ik_result_t result, res_next;

  logic                  in_xfer;
  logic [DIT_W-1:0]      unit_raw;
  logic [DIT_W-1:0]      unit;
  logic [LEN_W-1:0]      dit_len;
  logic [LEN_W-1:0]      dah_len;
  logic [PauseWideW-1:0] idle_wide;

  // output register frees when empty or its result is being taken
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // unit: zero reads as one tick, saturated at the cap
  assign unit_raw = (dit_ticks == '0) ? DIT_W'(1) : dit_ticks;
  assign unit     = (unit_raw > UNIT_CAP) ? UNIT_CAP : unit_raw;
  assign dit_len  = {1'b0, unit, 1'b0};   // 2 units
  assign dah_len  = {unit, 2'b00};        // 4 units

  assign idle_wide = PauseWideW'(idle_ticks);

  // -------------------------------------------------------------------------
  // One-pass state update for the item on the input ports
  // -------------------------------------------------------------------------
  always_comb begin
    logic               lev_dit;
    logic               lev_dah;
    logic               start;
    logic               start_dit;
    logic               was_dit;
    logic [LEN_W-1:0]   tl_dec;

    keyer_state_next  = keyer_state;
    squeeze_seen_next = squeeze_seen;
    phys_dit_next     = phys_dit;
    phys_dah_next     = phys_dah;
    ticks_left_next   = ticks_left;
    idle_seen_next    = idle_seen;
    idle_ticks_next   = idle_ticks;
    res_next          = '0;

    start     = 1'b0;
    start_dit = 1'b0;
    was_dit   = (keyer_state == ST_DIT);
    tl_dec    = (ticks_left != '0) ? ticks_left - LEN_W'(1) : ticks_left;

    if (op == OP_PADDLE) begin
      phys_dit_next = dit_pressed;
      phys_dah_next = dah_pressed;
    end

    // logical paddles after the swap, from the levels now in force
    lev_dit = reversed ? phys_dah_next : phys_dit_next;
    lev_dah = reversed ? phys_dit_next : phys_dah_next;

    if (op == OP_PADDLE) begin
      if (enabled) begin
        if (keyer_state != ST_IDLE) begin
          if (lev_dit && lev_dah) begin
            squeeze_seen_next = 1'b1;
          end
        end else if (lev_dit || lev_dah) begin
          start     = 1'b1;
          start_dit = lev_dit;   // a squeeze opens with a dit
        end
      end
    end else if (keyer_state == ST_IDLE) begin
      if (idle_ticks != '1) begin
        idle_ticks_next = idle_ticks + PAUSE_BITS'(1);
      end
    end else begin
      ticks_left_next = tl_dec;
      if (tl_dec == '0) begin
        // element expired: alternate, cross, repeat, mode B memory or stop
        if (lev_dit && lev_dah) begin
          start     = 1'b1;
          start_dit = ~was_dit;
        end else if (lev_dah) begin
          start     = 1'b1;
          start_dit = 1'b0;
        end else if (lev_dit) begin
          start     = 1'b1;
          start_dit = 1'b1;
        end else if (squeeze_seen && mode_b) begin
          start     = 1'b1;
          start_dit = ~was_dit;
        end else begin
          keyer_state_next       = ST_IDLE;
          squeeze_seen_next      = 1'b0;
          ticks_left_next        = '0;
          idle_seen_next         = 1'b1;
          idle_ticks_next        = '0;
          res_next.character_end = 1'b1;
        end
      end
    end

    if (start) begin
      if (keyer_state == ST_IDLE && idle_seen) begin
        res_next.pause_valid = 1'b1;
        res_next.pause_ticks = idle_wide[PAUSE_OUT_W-1:0];
      end
      keyer_state_next          = start_dit ? ST_DIT : ST_DAH;
      squeeze_seen_next         = lev_dit & lev_dah;
      ticks_left_next           = start_dit ? dit_len : dah_len;
      res_next.element_started  = 1'b1;
      res_next.element_is_dit   = start_dit;
      res_next.element_length   = start_dit ? dit_len : dah_len;
    end

    res_next.keying = (keyer_state_next != ST_IDLE);
  end

  // -------------------------------------------------------------------------
  // State, configuration and result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b1;
      mode_b       <= 1'b0;
      reversed     <= 1'b0;
      dit_ticks    <= DIT_TICKS_RESET;
      keyer_state  <= ST_IDLE;
      squeeze_seen <= 1'b0;
      phys_dit     <= 1'b0;
      phys_dah     <= 1'b0;
      ticks_left   <= '0;
      idle_seen    <= 1'b0;
      idle_ticks   <= '0;
      out_valid    <= 1'b0;
      result       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLED:   enabled   <= cfg_data[0];
          CFG_MODE_B:    mode_b    <= cfg_data[0];
          CFG_REVERSED:  reversed  <= cfg_data[0];
          CFG_DIT_TICKS: dit_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (in_xfer) begin
        keyer_state  <= keyer_state_next;
        squeeze_seen <= squeeze_seen_next;
        phys_dit     <= phys_dit_next;
        phys_dah     <= phys_dah_next;
        ticks_left   <= ticks_left_next;
        idle_seen    <= idle_seen_next;
        idle_ticks   <= idle_ticks_next;
        result       <= res_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid    <= 1'b0;
      end
    end
  end

  assign element_started = result.element_started;
  assign element_is_dit  = result.element_is_dit;
  assign element_length  = result.element_length;
  assign pause_valid     = result.pause_valid;
  assign pause_ticks     = result.pause_ticks;
  assign character_end   = result.character_end;
  assign keying          = result.keying;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `IK_ASSERT_IMPL(a_start_keys, out_valid && element_started, keying, "start without keying")
  `IK_ASSERT_IMPL(a_end_idle, out_valid && character_end, !keying && !element_started,
                  "character end while keying")
  `IK_ASSERT_IMPL(a_pause_start, out_valid && pause_valid, element_started,
                  "pause reported without a start")
  `IK_ASSERT_NEXT(a_xfer_fills, in_valid && !in_stall, out_valid, "accepted item lost")

endmodule
